// ----- src/scsa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types, size-class tables and codes for the size-class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

    localparam int CLASS_COUNT     = 10;
    localparam int CLS_W           = 4;
    localparam int PAGE_BYTES      = 4096;
    localparam int GRAN_PER_PAGE   = PAGE_BYTES / 8;
    localparam int GRAN_PAGE_W     = $clog2(GRAN_PER_PAGE);
    localparam int PAGE_OFF_W      = $clog2(PAGE_BYTES);
    localparam int SLOT_IDX_W      = 8;
    localparam int STEP_W          = 9;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 20;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT  = 2'd1;

    localparam logic [31:0] HEADER_BYTES = 32'd16;

    localparam logic [11:0] CLASS_BYTES [CLASS_COUNT] = '{
        12'd8, 12'd16, 12'd32, 12'd64, 12'd128,
        12'd256, 12'd512, 12'd1024, 12'd1536, 12'd2048
    };

    // slot size in granules: (class + 16 header, rounded to 8) / 8
    localparam logic [STEP_W-1:0] CLASS_STEP [CLASS_COUNT] = '{
        9'd3, 9'd4, 9'd6, 9'd10, 9'd18,
        9'd34, 9'd66, 9'd130, 9'd194, 9'd258
    };

    // slots per page: (4096 - 8) / slot bytes, at least one
    localparam logic [SLOT_IDX_W-1:0] CLASS_SPP [CLASS_COUNT] = '{
        8'd170, 8'd127, 8'd85, 8'd51, 8'd28,
        8'd15, 8'd7, 8'd3, 8'd2, 8'd1
    };

    typedef struct packed {
        logic        cmd;
        logic [11:0] request_size;
        logic [31:0] user_address;
    } t_req;

    typedef struct packed {
        logic [31:0] granted_address;
        logic        success;
        logic [4:0]  pages_remaining;
    } t_rsp;

    typedef struct packed {
        logic             ok;
        logic [CLS_W-1:0] idx;
    } t_cls;

    function automatic t_cls size_class(input logic [11:0] size);
        t_cls r;
        r.ok  = 1'b0;
        r.idx = '0;
        for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
            if (size <= CLASS_BYTES[i]) begin
                r.ok  = 1'b1;
                r.idx = CLS_W'(i);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- src/scsa_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// scsa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module scsa_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 8192
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- src/size_class_slab_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// size_class_slab_allocator
// Slab allocator with ten size classes, per-class LIFO free lists and pages
// carved on demand from a configured region.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready, t_req): alloc or free items.
//   Result channel (o_out_valid / i_out_ready, t_rsp): one result per item,
//   in request order.
//   Config channel (i_cfg_valid / o_cfg_ready): index 0 region base page,
//   index 1 page count; other indexes are dropped. Always ready; write only
//   while no request is in flight.
// Flow:
//   An alloc served from a free list passes through S_POP while the next
//   link is read from the link-store RAM. Other items push their result
//   in the cycle they are accepted. Results land in a two-entry output
//   queue, so requests keep flowing while a result waits; with the queue
//   full the request side holds ready low until the receiver takes one.
// Reset:
//   Free lists and cursors empty, no pages used, base page 1, page count 0.
//   The link store is not cleared; entries are read only after a free.
// ----------------------------------------------------------------------------
module size_class_slab_allocator
    import scsa_pkg::*;
#(
    parameter int MAX_PAGES = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_req                  i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_rsp                       o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LINK_DEPTH = MAX_PAGES * GRAN_PER_PAGE;
    localparam int GW         = $clog2(LINK_DEPTH);
    localparam int HW         = $clog2(LINK_DEPTH + 1);
    localparam int PW         = $clog2(MAX_PAGES + 1);
    localparam int CW         = PW + 5;

    typedef enum logic {S_IDLE, S_POP} t_state;

    t_state                r_state, n_state;
    logic [19:0]           r_base;
    logic [4:0]            r_page_count;
    logic [PW-1:0]         r_used, n_used;
    logic [HW-1:0]         r_head    [CLASS_COUNT];
    logic [HW-1:0]         n_head    [CLASS_COUNT];
    logic                  r_cur_vld [CLASS_COUNT];
    logic                  n_cur_vld [CLASS_COUNT];
    logic [GW-1:0]         r_cur_g   [CLASS_COUNT];
    logic [GW-1:0]         n_cur_g   [CLASS_COUNT];
    logic [SLOT_IDX_W-1:0] r_cur_idx [CLASS_COUNT];
    logic [SLOT_IDX_W-1:0] n_cur_idx [CLASS_COUNT];
    logic [CLS_W-1:0]      r_pop_cls, n_pop_cls;
    logic [GW-1:0]         r_pop_g, n_pop_g;

    // output queue
    t_rsp                  r_q [2];
    logic                  r_wr_ptr, r_rd_ptr;
    logic [1:0]            r_cnt;

    t_cls                  cls;
    logic                  in_acc, out_acc, push;
    logic                  grant_ok;
    logic [GW-1:0]         grant_g;
    logic                  free_ok;
    logic [31:0]           region_addr, free_off;
    logic [GW-1:0]         free_g;
    logic [CW-1:0]         avail, left;
    logic                  ram_we, ram_re;
    logic [GW-1:0]         ram_waddr, ram_raddr;
    logic [HW-1:0]         ram_wdata, ram_rdata;
    t_rsp                  rsp;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_q[r_rd_ptr];
    assign o_in_ready  = (r_state == S_IDLE) && (r_cnt != 2'd2);

    assign cls         = size_class(i_in_data.request_size);
    assign region_addr = {r_base, {PAGE_OFF_W{1'b0}}};
    assign avail       = (CW'(r_page_count) > CW'(MAX_PAGES)) ? CW'(MAX_PAGES)
                                                              : CW'(r_page_count);
    assign free_off    = i_in_data.user_address - HEADER_BYTES - region_addr;
    assign free_g      = free_off[GW+2:3];
    assign free_ok     = cls.ok && (i_in_data.user_address != 32'd0)
                         && (free_off[2:0] == 3'd0)
                         && ({12'd0, free_off[31:PAGE_OFF_W]} < 32'(avail));

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_head    = r_head;
        n_cur_vld = r_cur_vld;
        n_cur_g   = r_cur_g;
        n_cur_idx = r_cur_idx;
        n_pop_cls = r_pop_cls;
        n_pop_g   = r_pop_g;
        push      = 1'b0;
        grant_ok  = 1'b0;
        grant_g   = '0;
        ram_we    = 1'b0;
        ram_waddr = free_g;
        ram_wdata = r_head[cls.idx];
        ram_re    = 1'b0;
        ram_raddr = GW'(r_head[cls.idx] - 1'b1);
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.cmd == CMD_ALLOC) begin
                        if (!cls.ok) begin
                            push = 1'b1;
                        end else if (r_head[cls.idx] != '0) begin
                            ram_re    = 1'b1;
                            n_pop_cls = cls.idx;
                            n_pop_g   = ram_raddr;
                            n_state   = S_POP;
                        end else if (r_cur_vld[cls.idx]) begin
                            push     = 1'b1;
                            grant_ok = 1'b1;
                            grant_g  = r_cur_g[cls.idx];
                            n_cur_vld[cls.idx] = (SLOT_IDX_W'(r_cur_idx[cls.idx] + 1'b1)
                                                  < CLASS_SPP[cls.idx]);
                            n_cur_g[cls.idx]   = GW'(r_cur_g[cls.idx]
                                                     + GW'(CLASS_STEP[cls.idx]));
                            n_cur_idx[cls.idx] = SLOT_IDX_W'(r_cur_idx[cls.idx] + 1'b1);
                        end else if (CW'(r_used) < avail) begin
                            // take a fresh page, first slot goes out now
                            push     = 1'b1;
                            grant_ok = 1'b1;
                            grant_g  = GW'({r_used, {GRAN_PAGE_W{1'b0}}});
                            n_used   = PW'(r_used + 1'b1);
                            n_cur_vld[cls.idx] = (CLASS_SPP[cls.idx] > SLOT_IDX_W'(1));
                            n_cur_g[cls.idx]   = GW'(grant_g + GW'(CLASS_STEP[cls.idx]));
                            n_cur_idx[cls.idx] = SLOT_IDX_W'(1);
                        end else begin
                            push = 1'b1;
                        end
                    end else begin
                        push = 1'b1;
                        if (free_ok) begin
                            ram_we           = 1'b1;
                            n_head[cls.idx]  = HW'(free_g) + HW'(1);
                            grant_ok         = 1'b0;
                        end
                    end
                end
            end
            S_POP: begin
                push              = 1'b1;
                grant_ok          = 1'b1;
                grant_g           = r_pop_g;
                n_head[r_pop_cls] = ram_rdata;
                n_state           = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign left = (avail > CW'(n_used)) ? CW'(avail - CW'(n_used)) : '0;

    always_comb begin
        rsp.granted_address = grant_ok ? (region_addr + 32'({grant_g, 3'b000})
                                          + HEADER_BYTES) : 32'd0;
        // a free reports success without an address
        rsp.success         = grant_ok || ((r_state == S_IDLE) && in_acc
                                           && (i_in_data.cmd == CMD_FREE) && free_ok);
        rsp.pages_remaining = left[4:0];
    end

    scsa_ram #(
        .WIDTH (HW),
        .DEPTH (LINK_DEPTH)
    ) u_link_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_base       <= 20'd1;
            r_page_count <= 5'd0;
            r_used       <= '0;
            r_wr_ptr     <= 1'b0;
            r_rd_ptr     <= 1'b0;
            r_cnt        <= 2'd0;
            for (int i = 0; i < CLASS_COUNT; i++) begin
                r_head[i]    <= '0;
                r_cur_vld[i] <= 1'b0;
            end
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_head    <= n_head;
            r_cur_vld <= n_cur_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_REGION_BASE: r_base       <= i_cfg_data;
                    CFG_PAGE_COUNT:  r_page_count <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (out_acc) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, out_acc});
        end
        r_cur_g   <= n_cur_g;
        r_cur_idx <= n_cur_idx;
        r_pop_cls <= n_pop_cls;
        r_pop_g   <= n_pop_g;
        if (push) begin
            r_q[r_wr_ptr] <= rsp;
        end
    end

    // a list pop always follows an accepted alloc
    a_pop_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> $past(in_acc))
        else $error("pop state without an accepted item");

    a_no_accept_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> !o_in_ready)
        else $error("request accepted during list pop");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("output queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> ((r_cnt != 2'd2) || out_acc))
        else $error("result pushed into a full queue");

    a_single_ram_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("link store read and written in one cycle");

endmodule
`default_nettype wire

// ----- tb/size_class_slab_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_slab_allocator_tb
// Self-checking bench for the slab allocator. Drives alloc and free items
// through the request channel with random gaps and back-pressure, keeps its
// own model of the free lists, cursors and page usage, and checks every
// result field in order. Registers are rewritten between phases only.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_tb;
    import scsa_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int NUM_CLASSES = 10;
    localparam int PG_BYTES    = 4096;
    localparam int GRANULES    = PG_BYTES / 8;
    localparam int MAX_PG      = 16;
    localparam int LINK_WORDS  = MAX_PG * GRANULES;
    localparam int IDLE_PCT    = 14;
    localparam int POOL_CAP    = 64;
    localparam int DRAIN_WAIT  = 10;

    typedef struct {
        logic [31:0] addr;
        logic [11:0] size;
    } t_live_obj;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    t_req                  req_data  = '0;
    logic                  in_ready;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    t_rsp                  rsp_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic calm      = 1'b0;
    logic req_fired = 1'b0;

    t_req      req_queue [$];
    t_rsp      due_rsps  [$];
    t_live_obj live_objs [$];
    int unsigned items_queued   = 0;
    int unsigned items_taken    = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // allocator model state
    int unsigned cls_bytes [NUM_CLASSES] = '{8, 16, 32, 64, 128, 256, 512, 1024, 1536, 2048};
    int unsigned free_head  [NUM_CLASSES];
    int unsigned fresh_slot [NUM_CLASSES];
    int unsigned link_mem   [LINK_WORDS];
    int unsigned pages_taken;
    logic [19:0] base_page;
    logic [4:0]  page_cnt;

    size_class_slab_allocator #(
        .MAX_PAGES (MAX_PG)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_ready (rsp_ready),
        .o_out_data  (rsp_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic int class_of(input logic [11:0] size);
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (size <= cls_bytes[i]) return i;
        end
        return -1;
    endfunction

    function automatic int unsigned slot_len(input int c);
        return (cls_bytes[c] + 32'd16 + 32'd7) & ~32'd7;
    endfunction

    function automatic int unsigned per_page(input int c);
        int unsigned n;
        n = (PG_BYTES - 8) / slot_len(c);
        return (n == 0) ? 1 : n;
    endfunction

    function automatic int unsigned usable_pages();
        return (page_cnt > MAX_PG) ? MAX_PG : page_cnt;
    endfunction

    function automatic logic [31:0] region_start();
        return {base_page, 12'h000};
    endfunction

    // next unhanded slot after granule g, 0 once the page is used up
    function automatic int unsigned step_cursor(input int c, input int unsigned g);
        int unsigned idx;
        idx = ((g % GRANULES) * 8) / slot_len(c);
        if (idx + 1 >= per_page(c)) return 0;
        return g + slot_len(c) / 8 + 1;
    endfunction

    function automatic t_rsp serve_request(input t_req r);
        int          c;
        int unsigned g;
        int unsigned left;
        logic        got;
        logic [31:0] off;
        t_rsp        rsp;
        c   = class_of(r.request_size);
        g   = 0;
        got = 1'b0;
        rsp = '0;
        if (c >= 0 && r.cmd == CMD_ALLOC) begin
            if (free_head[c] != 0 && free_head[c] <= LINK_WORDS) begin
                g = free_head[c] - 1;
                free_head[c] = link_mem[g];
                got = 1'b1;
            end else if (fresh_slot[c] != 0) begin
                g = fresh_slot[c] - 1;
                fresh_slot[c] = step_cursor(c, g);
                got = 1'b1;
            end else if (pages_taken < usable_pages()) begin
                g = pages_taken * GRANULES;
                pages_taken++;
                fresh_slot[c] = step_cursor(c, g);
                got = 1'b1;
            end
            if (got) begin
                rsp.granted_address = region_start() + g * 8 + 32'd16;
                rsp.success = 1'b1;
            end
        end else if (c >= 0 && r.cmd == CMD_FREE && r.user_address != 32'h0) begin
            off = r.user_address - 32'd16 - region_start();
            if (off[2:0] == 3'd0 && off < usable_pages() * PG_BYTES) begin
                g = off / 8;
                link_mem[g] = free_head[c];
                free_head[c] = g + 1;
                rsp.success = 1'b1;
            end
        end
        left = (usable_pages() > pages_taken) ? usable_pages() - pages_taken : 0;
        rsp.pages_remaining = left[4:0];
        return rsp;
    endfunction

    // allocs across the classes, mostly sane frees of live or carved objects, plus some that must be ignored
    function automatic t_req make_req();
        t_req        r;
        int          c;
        int unsigned pick;
        int unsigned k;
        int unsigned avail;
        logic [31:0] region;
        avail  = usable_pages();
        region = region_start();
        c      = $urandom_range(NUM_CLASSES - 1, 0);
        pick   = $urandom_range(99);
        r.cmd  = CMD_ALLOC;
        r.user_address = $urandom();
        if ($urandom_range(2) == 0 || c == 0)
            r.request_size = 12'((c == 0) ? $urandom_range(8, 0) : cls_bytes[c]);
        else
            r.request_size = 12'($urandom_range(cls_bytes[c], cls_bytes[c - 1] + 1));
        if (pick < 45) begin
            if ($urandom_range(19) == 0) r.request_size = 12'($urandom_range(4095, 2049));
        end else begin
            r.cmd = CMD_FREE;
            if (pick < 75 && live_objs.size() > 0) begin
                k = $urandom_range(live_objs.size() - 1);
                r.user_address = live_objs[k].addr;
                if ($urandom_range(6) != 0) r.request_size = live_objs[k].size;
                live_objs.delete(k);
            end else if (pick < 90 && avail > 0) begin
                r.user_address = region + $urandom_range(avail - 1) * PG_BYTES
                                 + $urandom_range(per_page(c) - 1) * slot_len(c) + 32'd16;
            end else begin
                case ($urandom_range(5))
                    0: r.user_address = 32'h0;
                    1: r.user_address = region + 32'd16 + $urandom_range(7, 1);
                    2: ;
                    3: r.user_address = region + avail * PG_BYTES + 32'd16;
                    4: r.user_address = region + 32'd8;
                    default: begin
                        r.user_address = region + 32'd16;
                        r.request_size = 12'($urandom_range(4095, 2049));
                    end
                endcase
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    endtask

    task automatic send(input logic cmd, input logic [11:0] size, input logic [31:0] addr);
        t_req r;
        r.cmd          = cmd;
        r.request_size = size;
        r.user_address = addr;
        req_queue.push_back(r);
        items_queued++;
    endtask

    task automatic wait_idle();
        do @(negedge clk); while (items_taken != items_queued || due_rsps.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [19:0] base, input logic [4:0] count);
        wait_idle();
        write_reg(CFG_REGION_BASE, CFG_DATA_W'(base));
        write_reg(CFG_PAGE_COUNT, CFG_DATA_W'(count));
        @(negedge clk);
        cfg_valid <= 1'b0;
        // addresses from the old base mostly fall outside the new region
        live_objs.delete();
    endtask

    task automatic random_batch(input int n);
        int   sent;
        t_req r;
        sent = 0;
        while (sent < n) begin
            if (req_queue.size() < 4) begin
                r = make_req();
                send(r.cmd, r.request_size, r.user_address);
                sent++;
            end else begin
                @(negedge clk);
            end
        end
    endtask

    // request driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (!req_valid || req_fired) begin
                if (req_queue.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    req_data  <= req_queue.pop_front();
                    req_valid <= 1'b1;
                end else begin
                    req_valid <= 1'b0;
                end
            end
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: register writes, accepted items and results
    always @(posedge clk) begin : monitor
        t_rsp      want;
        t_live_obj obj;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_REGION_BASE: base_page = cfg_data[19:0];
                    CFG_PAGE_COUNT:  page_cnt  = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (rsp_valid && rsp_ready) begin
                if (due_rsps.size() == 0) begin
                    report_mismatch("result with none due", rsp_data.granted_address, 32'h0);
                end else begin
                    want = due_rsps.pop_front();
                    if (rsp_data.granted_address !== want.granted_address)
                        report_mismatch("granted_address", rsp_data.granted_address,
                                        want.granted_address);
                    if (rsp_data.success !== want.success)
                        report_mismatch("success", 32'(rsp_data.success), 32'(want.success));
                    if (rsp_data.pages_remaining !== want.pages_remaining)
                        report_mismatch("pages_remaining", 32'(rsp_data.pages_remaining),
                                        32'(want.pages_remaining));
                end
            end
            req_fired = req_valid && in_ready;
            if (req_fired) begin
                want = serve_request(req_data);
                due_rsps.push_back(want);
                items_taken++;
                if (req_data.cmd == CMD_ALLOC && want.success && live_objs.size() < POOL_CAP) begin
                    obj.addr = want.granted_address;
                    obj.size = req_data.request_size;
                    live_objs.push_back(obj);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        foreach (free_head[i]) begin
            free_head[i]  = 0;
            fresh_slot[i] = 0;
        end
        pages_taken = 0;
        base_page   = 20'd1;
        page_cnt    = 5'd0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty region: every alloc fails, nothing to free into
        configure(20'd1, 5'd0);
        send(CMD_ALLOC, 12'd8,    32'h0);
        send(CMD_FREE,  12'd8,    32'h0);
        send(CMD_ALLOC, 12'd4095, 32'h0);
        send(CMD_FREE,  12'd8,    32'h0000_1010);

        // two pages at the top of the address space, so the second wraps
        configure(20'hFFFFF, 5'd2);
        send(CMD_ALLOC, 12'd0,    32'hFFFF_FFFF);
        send(CMD_ALLOC, 12'd8,    32'h0);
        send(CMD_ALLOC, 12'd2048, 32'h0);
        send(CMD_ALLOC, 12'd1536, 32'h0);
        send(CMD_ALLOC, 12'd2049, 32'h0);
        send(CMD_FREE,  12'd2048, 32'h0000_0010);
        send(CMD_FREE,  12'd2048, 32'h0000_0014);
        send(CMD_FREE,  12'd4095, 32'hFFFF_FFFF);
        send(CMD_FREE,  12'd16,   32'hFFFF_FFFF);
        send(CMD_FREE,  12'd64,   32'h0000_2010);
        send(CMD_FREE,  12'd64,   32'hFFFF_F010);
        send(CMD_ALLOC, 12'd64,   32'h0);
        send(CMD_ALLOC, 12'd2000, 32'h0);
        send(CMD_ALLOC, 12'd2048, 32'h0);
        send(CMD_FREE,  12'd8,    32'h0000_1008);
        send(CMD_ALLOC, 12'd1,    32'h0);
        send(CMD_FREE,  12'd8,    32'hFFFF_F000);
        send(CMD_ALLOC, 12'd9,    32'h0);

        configure(20'($urandom_range(20'hFFFFF, 1)), 5'd6);
        random_batch(300);
        configure(20'd1, 5'd16);
        calm <= 1'b1;
        random_batch(300);
        // page count above the cap is clamped
        configure(20'hFFFFF, 5'd31);
        calm <= 1'b0;
        random_batch(300);
        configure(20'($urandom_range(20'hFFFFF, 1)), 5'd0);
        random_batch(150);
        configure(20'($urandom_range(20'hFFFFF, 1)), 5'($urandom_range(16, 10)));
        random_batch(450);
        configure(20'h80000, 5'd16);
        random_batch(450);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (due_rsps.size() != 0)
            report_mismatch("results still due at end", 32'(due_rsps.size()), 32'h0);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
src/scsa_pkg.sv
src/scsa_ram.sv
src/size_class_slab_allocator.sv
tb/size_class_slab_allocator_tb.sv
